// ===== hdl/euler_motion_step_with_drag_clamp_assert.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the motion step block
// Clocked on clk_i; the first form is muted while rst_ni is low.
// ----------------------------------------------------------------------------
`ifndef EULER_MOTION_STEP_WITH_DRAG_CLAMP_ASSERT_SVH
`define EULER_MOTION_STEP_WITH_DRAG_CLAMP_ASSERT_SVH

// checked outside reset
`define EMSD_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error(msg);

// checked at every edge, reset included
`define EMSD_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

// ===== hdl/emsd_pkg.sv =====
// ----------------------------------------------------------------------------
// emsd_pkg
// Shared types, stage indexes and fixed-point helpers of the motion step.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package emsd_pkg;

  localparam int unsigned NLANE   = 3;
  localparam int unsigned SQ_STG  = 32;
  localparam int unsigned DIV_STG = 32;

  // stage at which each value is registered
  localparam int unsigned ST_SQ  = 4;
  localparam int unsigned ST_FL  = ST_SQ + 1;
  localparam int unsigned ST_SPD = ST_SQ + SQ_STG;
  localparam int unsigned ST_Q   = ST_SPD + 2 + DIV_STG;
  localparam int unsigned ST_SEL = ST_Q + 1;
  localparam int unsigned ST_PD  = ST_SEL + 1;
  localparam int unsigned LAT    = ST_PD + 1;

  typedef struct packed {
    logic [2:0][31:0] pos;
    logic [15:0]      dt;
    logic [30:0]      lim;
  } sb_t;

  typedef struct packed {
    logic zero;
    logic resc;
  } fl_t;

  // round to nearest, ties up, then drop 16 fraction bits
  function automatic logic signed [49:0] rnd16(input logic signed [65:0] x);
    logic signed [66:0] t;
    t = {x[65], x} + 67'sd32768;
    return t[65:16];
  endfunction

  function automatic logic signed [31:0] sat32(input logic signed [49:0] x);
    logic signed [31:0] r;
    if (x > 50'sd2147483647) begin
      r = 32'sh7fff_ffff;
    end else if (x < -50'sd2147483648) begin
      r = 32'sh8000_0000;
    end else begin
      r = x[31:0];
    end
    return r;
  endfunction

endpackage

`default_nettype wire

// ===== hdl/emsd_vel_lane.sv =====
// ----------------------------------------------------------------------------
// emsd_vel_lane
// One axis: v1 = v + a*dt, v2 = v1 * factor, then |v2| squared.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module emsd_vel_lane (
  input  logic               clk_i,
  input  logic               en_i,
  input  logic signed [31:0] vel_i,
  input  logic signed [31:0] acc_i,
  input  logic [15:0]        dt_i,
  input  logic signed [32:0] fac_i,
  output logic signed [31:0] v2_o,
  output logic [63:0]        mag2_o
);
  import emsd_pkg::*;

  logic signed [48:0] p1;
  logic signed [49:0] s1;
  logic signed [64:0] p2;
  logic [32:0]        m;
  logic signed [31:0] v1_q, v2_q;
  logic [63:0]        mag2_q;

  always_comb begin
    p1 = 49'(acc_i) * 49'($signed({1'b0, dt_i}));
    s1 = 50'(vel_i) + rnd16(66'(p1));
    p2 = 65'(v1_q) * 65'(fac_i);
    m  = v2_q[31] ? 33'(-(33'(v2_q))) : 33'(v2_q);
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      v1_q   <= sat32(s1);
      v2_q   <= sat32(rnd16(66'(p2)));
      mag2_q <= 64'(m[31:0]) * 64'(m[31:0]);
    end
  end

  assign v2_o   = v2_q;
  assign mag2_o = mag2_q;

endmodule

`default_nettype wire

// ===== hdl/emsd_isqrt.sv =====
// ----------------------------------------------------------------------------
// emsd_isqrt
// Pipelined floor square root of a 64-bit word, two radicand bits a stage.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module emsd_isqrt (
  input  logic        clk_i,
  input  logic        en_i,
  input  logic [63:0] n_i,
  output logic [31:0] root_o
);
  import emsd_pkg::*;

  logic [34:0] rem_q  [SQ_STG];
  logic [31:0] root_q [SQ_STG];
  logic [63:0] n_q    [SQ_STG];

  for (genvar j = 0; j < SQ_STG; j++) begin : g_stg
    logic [34:0] rin;
    logic [31:0] oin;
    logic [63:0] nin;
    logic [34:0] cur;
    logic [34:0] trial;

    if (j == 0) begin : g_first
      assign rin = '0;
      assign oin = '0;
      assign nin = n_i;
    end else begin : g_next
      assign rin = rem_q[j-1];
      assign oin = root_q[j-1];
      assign nin = n_q[j-1];
    end

    assign cur   = {rin[32:0], nin[63-2*j -: 2]};
    assign trial = {1'b0, oin, 2'b01};

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        n_q[j] <= nin;
        if (cur >= trial) begin
          rem_q[j]  <= cur - trial;
          root_q[j] <= {oin[30:0], 1'b1};
        end else begin
          rem_q[j]  <= cur;
          root_q[j] <= {oin[30:0], 1'b0};
        end
      end
    end
  end

  assign root_o = root_q[SQ_STG-1];

endmodule

`default_nettype wire

// ===== hdl/emsd_div.sv =====
// ----------------------------------------------------------------------------
// emsd_div
// Rescale of one axis: (mag*limit + speed/2) / speed, restoring divider,
// one quotient bit a stage.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module emsd_div (
  input  logic        clk_i,
  input  logic        en_i,
  input  logic [31:0] mag_i,
  input  logic [30:0] lim_i,
  input  logic [31:0] spd_i,
  output logic [31:0] q_o
);
  import emsd_pkg::*;

  logic [62:0] num_q;
  logic [63:0] nadd_q;
  logic [31:0] d0_q, d1_q;
  logic [31:0] rem_q [DIV_STG];
  logic [31:0] nl_q  [DIV_STG];
  logic [31:0] d_q   [DIV_STG];
  logic [31:0] q_q   [DIV_STG];

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      num_q  <= 63'(mag_i) * 63'(lim_i);
      d0_q   <= spd_i;
      nadd_q <= 64'(num_q) + 64'(d0_q >> 1);
      d1_q   <= d0_q;
    end
  end

  for (genvar j = 0; j < DIV_STG; j++) begin : g_stg
    logic [31:0] rin, nlin, din, qin;
    logic [32:0] cur;
    logic        hit;

    if (j == 0) begin : g_first
      assign rin  = nadd_q[63:32];
      assign nlin = nadd_q[31:0];
      assign din  = d1_q;
      assign qin  = '0;
    end else begin : g_next
      assign rin  = rem_q[j-1];
      assign nlin = nl_q[j-1];
      assign din  = d_q[j-1];
      assign qin  = q_q[j-1];
    end

    assign cur = {rin, nlin[DIV_STG-1-j]};
    assign hit = cur >= {1'b0, din};

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[j] <= hit ? 32'(cur - {1'b0, din}) : cur[31:0];
        nl_q[j]  <= nlin;
        d_q[j]   <= din;
        q_q[j]   <= {qin[30:0], hit};
      end
    end
  end

  assign q_o = q_q[DIV_STG-1];

endmodule

`default_nettype wire

// ===== hdl/euler_motion_step_with_drag_clamp.sv =====
// ----------------------------------------------------------------------------
// euler_motion_step_with_drag_clamp
// Semi-implicit Euler step of one body per item with linear drag, speed
// clamp and ground plane, Q16.16 with saturation.
// ----------------------------------------------------------------------------
// channel | handshake               | payload
// in      | in_valid_i / in_ready_o | vel, acc, drag_coef, speed_limit, pos, time_step
// out     | out_valid_o/ out_ready_i| new_vel, new_pos
//
// One item per cycle while results are accepted; the depth is set by the
// 32-stage square root and the 32-stage rescale divider.
// Reset clears only the stage valid bits; no clearing pass.
// An unaccepted result stalls the pipe; the entry stage still fills if empty.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "euler_motion_step_with_drag_clamp_assert.svh"

module euler_motion_step_with_drag_clamp (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic signed [31:0] vel_x_i,
  input  logic signed [31:0] vel_y_i,
  input  logic signed [31:0] vel_z_i,
  input  logic signed [31:0] acc_x_i,
  input  logic signed [31:0] acc_y_i,
  input  logic signed [31:0] acc_z_i,
  input  logic [30:0]        drag_coef_i,
  input  logic [30:0]        speed_limit_i,
  input  logic signed [31:0] pos_x_i,
  input  logic signed [31:0] pos_y_i,
  input  logic signed [31:0] pos_z_i,
  input  logic [15:0]        time_step_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic signed [31:0] new_vel_x_o,
  output logic signed [31:0] new_vel_y_o,
  output logic signed [31:0] new_vel_z_o,
  output logic signed [31:0] new_pos_x_o,
  output logic signed [31:0] new_pos_y_o,
  output logic signed [31:0] new_pos_z_o
);
  import emsd_pkg::*;

  logic              adv, ld0;
  logic [LAT:0]      vld_q;
  logic [2:0][31:0]  vel0_q, acc0_q;
  logic [30:0]       drag0_q;
  sb_t               sb_q [ST_PD+1];
  logic [2:0][31:0]  vd_q [3:ST_Q];
  fl_t               fl_q [ST_FL:ST_Q];
  logic signed [32:0] fac_q;
  logic [63:0]       sq_q;
  logic [61:0]       lim2_q;
  logic [31:0]       spd_w;
  logic [2:0][31:0]  v2_w;
  logic [63:0]       mag2_w [NLANE];
  logic [31:0]       q_w    [NLANE];
  logic [31:0]       mag_w  [NLANE];
  logic signed [31:0] vs_q  [NLANE];
  logic signed [31:0] vs2_q [NLANE];
  logic signed [33:0] pd_q  [NLANE];
  logic signed [31:0] nv_q  [NLANE];
  logic signed [31:0] np_q  [NLANE];
  logic [46:0]       dp;
  logic signed [49:0] dr;

  assign adv        = !vld_q[LAT] || out_ready_i;
  assign ld0        = adv || !vld_q[0];
  assign in_ready_o = ld0;
  assign out_valid_o = vld_q[LAT];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      if (ld0) vld_q[0] <= in_valid_i;
      if (adv) vld_q[LAT:1] <= vld_q[LAT-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (ld0 && in_valid_i) begin
      vel0_q      <= {vel_z_i, vel_y_i, vel_x_i};
      acc0_q      <= {acc_z_i, acc_y_i, acc_x_i};
      drag0_q     <= drag_coef_i;
      sb_q[0].pos <= {pos_z_i, pos_y_i, pos_x_i};
      sb_q[0].dt  <= time_step_i;
      sb_q[0].lim <= speed_limit_i;
    end
    if (adv) begin
      for (int k = 1; k <= ST_PD; k++) sb_q[k] <= sb_q[k-1];
    end
  end

  // drag factor, shared by all lanes
  always_comb begin
    dp = 47'(drag0_q) * 47'(sb_q[0].dt);
    dr = rnd16(66'(dp));
  end

  for (genvar i = 0; i < NLANE; i++) begin : g_lane
    emsd_vel_lane u_lane (
      .clk_i  (clk_i),
      .en_i   (adv),
      .vel_i  ($signed(vel0_q[i])),
      .acc_i  ($signed(acc0_q[i])),
      .dt_i   (sb_q[0].dt),
      .fac_i  (fac_q),
      .v2_o   (v2_w[i]),
      .mag2_o (mag2_w[i])
    );

    assign mag_w[i] = vd_q[ST_SPD][i][31] ? 32'(-(33'($signed(vd_q[ST_SPD][i]))))
                                          : vd_q[ST_SPD][i];

    emsd_div u_div (
      .clk_i (clk_i),
      .en_i  (adv),
      .mag_i (mag_w[i]),
      .lim_i (sb_q[ST_SPD].lim),
      .spd_i (spd_w),
      .q_o   (q_w[i])
    );
  end

  emsd_isqrt u_isqrt (
    .clk_i  (clk_i),
    .en_i   (adv),
    .n_i    (sq_q),
    .root_o (spd_w)
  );

  // merge: squared speed, limit tests, then velocity select and position
  always_ff @(posedge clk_i) begin
    if (adv) begin
      fac_q  <= 33'sd65536 - $signed(dr[32:0]);
      sq_q   <= mag2_w[0] + mag2_w[1] + mag2_w[2];
      lim2_q <= 62'(sb_q[ST_SQ-1].lim) * 62'(sb_q[ST_SQ-1].lim);
      vd_q[3] <= v2_w;
      for (int k = 4; k <= ST_Q; k++) vd_q[k] <= vd_q[k-1];
      fl_q[ST_FL].zero <= (sq_q <= 64'h4000_0000) || (sb_q[ST_SQ].lim == '0);
      fl_q[ST_FL].resc <= sq_q > {2'b00, lim2_q};
      for (int k = ST_FL + 1; k <= ST_Q; k++) fl_q[k] <= fl_q[k-1];
      for (int i = 0; i < NLANE; i++) begin
        if (fl_q[ST_Q].zero) begin
          vs_q[i] <= '0;
        end else if (fl_q[ST_Q].resc) begin
          vs_q[i] <= vd_q[ST_Q][i][31] ? $signed(~q_w[i] + 32'd1) : $signed(q_w[i]);
        end else begin
          vs_q[i] <= $signed(vd_q[ST_Q][i]);
        end
        vs2_q[i] <= vs_q[i];
        pd_q[i]  <= 34'(rnd16(66'(49'(vs_q[i]) *
                                  49'($signed({1'b0, sb_q[ST_SEL].dt})))));
        nv_q[i]  <= vs2_q[i];
        if (i == 1 && sat32(50'($signed(sb_q[ST_PD].pos[i])) + 50'(pd_q[i])) <= 32'sd0) begin
          np_q[i] <= '0;
        end else begin
          np_q[i] <= sat32(50'($signed(sb_q[ST_PD].pos[i])) + 50'(pd_q[i]));
        end
      end
    end
  end

  assign new_vel_x_o = nv_q[0];
  assign new_vel_y_o = nv_q[1];
  assign new_vel_z_o = nv_q[2];
  assign new_pos_x_o = np_q[0];
  assign new_pos_y_o = np_q[1];
  assign new_pos_z_o = np_q[2];

  `EMSD_ASSERT(a_stall_only_on_out, !in_ready_o |-> (out_valid_o && !out_ready_i), "input blocked without output stall")
  `EMSD_ASSERT(a_ground, out_valid_o |-> !new_pos_y_o[31], "height below ground")
  `EMSD_ASSERT(a_flow, (adv && vld_q[LAT-1]) |=> out_valid_o, "item lost before output")
  `EMSD_ASSERT(a_stop, (adv && fl_q[ST_Q].zero) |=> (vs_q[0] == '0 && vs_q[1] == '0 && vs_q[2] == '0), "stop not applied")
  `EMSD_ASSERT_ALWAYS(a_rst_idle, !rst_ni |-> !out_valid_o, "output valid in reset")

endmodule

`default_nettype wire

// ===== tb/tb_euler_motion_step_with_drag_clamp.sv =====
// ----------------------------------------------------------------------------
// Testbench for euler_motion_step_with_drag_clamp
// Drives body items through the valid/ready input channel and checks each
// result in order against a fixed-point model of the motion step. Both sides
// idle at random. There is one long receiver hold-off so that the pipe fills,
// and one sender pause that waits until every expected result has come.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

typedef struct {
  logic signed [31:0] vel [3];
  logic signed [31:0] acc [3];
  logic [30:0]        drag;
  logic [30:0]        lim;
  logic signed [31:0] pos [3];
  logic [15:0]        dt;
} body_t;

typedef struct {
  logic signed [31:0] vel [3];
  logic signed [31:0] pos [3];
} motion_t;

class motion_scoreboard;
  motion_t want_q [$];
  int      errors;
  int      checked;
  int      stopped;
  int      clamped;
  int      grounded;

  function longint r16(longint x);
    return (x + 64'sd32768) >>> 16;
  endfunction

  function longint sat32(longint x);
    if (x > 64'sd2147483647) return 64'sd2147483647;
    if (x < -64'sd2147483648) return -64'sd2147483648;
    return x;
  endfunction

  function bit [63:0] isqrt(bit [63:0] n);
    bit [63:0] res;
    bit [63:0] b;
    res = 0;
    b = 64'd1 << 62;
    while (b > n) b = b >> 2;
    while (b != 0) begin
      if (n >= res + b) begin
        n = n - (res + b);
        res = (res >> 1) + b;
      end else begin
        res = res >> 1;
      end
      b = b >> 2;
    end
    return res;
  endfunction

  function void note(body_t it);
    longint    v [3];
    longint    p [3];
    longint    drag;
    longint    dt;
    longint    factor;
    longint    v1;
    longint    r;
    bit [63:0] sq;
    bit [63:0] m;
    bit [63:0] lim;
    bit [63:0] spd;
    bit [63:0] q;
    motion_t   res;
    drag = longint'({33'd0, it.drag});
    dt = longint'({48'd0, it.dt});
    lim = {33'd0, it.lim};
    factor = 65536 - r16(drag * dt);
    sq = 0;
    for (int i = 0; i < 3; i++) begin
      v1 = sat32(longint'(it.vel[i]) + r16(longint'(it.acc[i]) * dt));
      v[i] = sat32(r16(v1 * factor));
      p[i] = longint'(it.pos[i]);
      m = (v[i] < 0) ? 64'(-v[i]) : 64'(v[i]);
      sq = sq + m * m;
    end
    if (sq <= 64'h4000_0000 || lim == 0) begin
      for (int i = 0; i < 3; i++) v[i] = 0;
      stopped++;
    end else if (sq > lim * lim) begin
      spd = isqrt(sq);
      for (int i = 0; i < 3; i++) begin
        m = (v[i] < 0) ? 64'(-v[i]) : 64'(v[i]);
        q = (m * lim + spd / 2) / spd;
        r = longint'(q);
        v[i] = sat32(v[i] < 0 ? -r : r);
      end
      clamped++;
    end
    for (int i = 0; i < 3; i++) p[i] = sat32(p[i] + r16(v[i] * dt));
    if (p[1] <= 0) begin
      p[1] = 0;
      grounded++;
    end
    for (int i = 0; i < 3; i++) begin
      res.vel[i] = v[i][31:0];
      res.pos[i] = p[i][31:0];
    end
    want_q.push_back(res);
  endfunction

  function void check(motion_t got);
    motion_t w;
    checked++;
    if (want_q.size() == 0) begin
      $display("%0t: result with nothing expected", $time);
      errors++;
      return;
    end
    w = want_q.pop_front();
    for (int i = 0; i < 3; i++) begin
      if (got.vel[i] !== w.vel[i]) begin
        $display("%0t: new_vel[%0d] expected %0d actual %0d", $time, i, w.vel[i], got.vel[i]);
        errors++;
      end
      if (got.pos[i] !== w.pos[i]) begin
        $display("%0t: new_pos[%0d] expected %0d actual %0d", $time, i, w.pos[i], got.pos[i]);
        errors++;
      end
    end
  endfunction

  function int pending();
    return want_q.size();
  endfunction
endclass

module tb_euler_motion_step_with_drag_clamp;
  localparam int LIMIT_CYCLES = 400000;
  localparam int DRAIN_CYCLES = 120;
  localparam int HOLD_CYCLES  = 300;

  logic               clk_i;
  logic               rst_ni;
  logic               in_valid_i;
  logic               in_ready_o;
  logic signed [31:0] vel_x_i, vel_y_i, vel_z_i;
  logic signed [31:0] acc_x_i, acc_y_i, acc_z_i;
  logic [30:0]        drag_coef_i;
  logic [30:0]        speed_limit_i;
  logic signed [31:0] pos_x_i, pos_y_i, pos_z_i;
  logic [15:0]        time_step_i;
  logic               out_valid_o;
  logic               out_ready_i;
  logic signed [31:0] new_vel_x_o, new_vel_y_o, new_vel_z_o;
  logic signed [31:0] new_pos_x_o, new_pos_y_o, new_pos_z_o;

  motion_scoreboard sb;
  int  cycles;
  bit  quiet;
  bit  hold_req;
  int  sent;

  euler_motion_step_with_drag_clamp u_top (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .in_valid_i(in_valid_i), .in_ready_o(in_ready_o),
    .vel_x_i(vel_x_i), .vel_y_i(vel_y_i), .vel_z_i(vel_z_i),
    .acc_x_i(acc_x_i), .acc_y_i(acc_y_i), .acc_z_i(acc_z_i),
    .drag_coef_i(drag_coef_i), .speed_limit_i(speed_limit_i),
    .pos_x_i(pos_x_i), .pos_y_i(pos_y_i), .pos_z_i(pos_z_i),
    .time_step_i(time_step_i),
    .out_valid_o(out_valid_o), .out_ready_i(out_ready_i),
    .new_vel_x_o(new_vel_x_o), .new_vel_y_o(new_vel_y_o), .new_vel_z_o(new_vel_z_o),
    .new_pos_x_o(new_pos_x_o), .new_pos_y_o(new_pos_y_o), .new_pos_z_o(new_pos_z_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  initial begin
    cycles = 0;
    forever begin
      @(posedge clk_i);
      cycles++;
      if (cycles > LIMIT_CYCLES) begin
        $display("timeout after %0d cycles", cycles);
        $display("FAIL euler_motion_step_with_drag_clamp");
        $finish;
      end
    end
  end

  function bit idle_roll();
    return !quiet && ($urandom_range(99) < 17);
  endfunction

  // receiver
  initial begin
    int hold;
    hold = 0;
    out_ready_i = 1'b0;
    forever begin
      @(posedge clk_i);
      if (rst_ni && out_valid_o && out_ready_i) begin
        motion_t got;
        got.vel[0] = new_vel_x_o; got.vel[1] = new_vel_y_o; got.vel[2] = new_vel_z_o;
        got.pos[0] = new_pos_x_o; got.pos[1] = new_pos_y_o; got.pos[2] = new_pos_z_o;
        sb.check(got);
      end
      @(negedge clk_i);
      if (hold_req && hold == 0) begin
        hold = HOLD_CYCLES;
        hold_req = 0;
      end
      if (hold > 0) begin
        hold--;
        out_ready_i = 1'b0;
      end else begin
        out_ready_i = !idle_roll();
      end
    end
  end

  task automatic drive(body_t it);
    while (idle_roll()) begin
      in_valid_i = 1'b0;
      @(negedge clk_i);
    end
    in_valid_i = 1'b1;
    vel_x_i = it.vel[0]; vel_y_i = it.vel[1]; vel_z_i = it.vel[2];
    acc_x_i = it.acc[0]; acc_y_i = it.acc[1]; acc_z_i = it.acc[2];
    drag_coef_i = it.drag; speed_limit_i = it.lim;
    pos_x_i = it.pos[0]; pos_y_i = it.pos[1]; pos_z_i = it.pos[2];
    time_step_i = it.dt;
    do @(posedge clk_i); while (!in_ready_o);
    sb.note(it);
    sent++;
    @(negedge clk_i);
  endtask

  function automatic logic signed [31:0] small_val(int span);
    return $signed($urandom_range(2 * span)) - span;
  endfunction

  function automatic body_t rand_body();
    body_t it;
    int    mode;
    mode = $urandom_range(99);
    for (int i = 0; i < 3; i++) begin
      if (mode < 60) begin
        it.vel[i] = small_val(32'h000a_0000);
        it.acc[i] = small_val(32'h0014_0000);
        it.pos[i] = small_val(32'h0100_0000);
      end else begin
        it.vel[i] = $urandom;
        it.acc[i] = $urandom;
        it.pos[i] = $urandom;
      end
    end
    if (mode < 60) begin
      it.drag = 31'($urandom_range(32'h0004_0000));
      it.lim = 31'($urandom_range(32'h000c_0000));
      it.dt = 16'($urandom_range(16'h1000));
      if ($urandom_range(9) == 0) it.lim = 0;
      if ($urandom_range(5) == 0) it.pos[1] = -$signed($urandom_range(16'hffff));
    end else begin
      it.drag = 31'($urandom);
      it.lim = 31'($urandom);
      it.dt = 16'($urandom);
      if (mode > 90) it.drag = 31'($urandom_range(16'hffff));
    end
    return it;
  endfunction

  function automatic body_t mk(longint vx, longint vy, longint vz, longint ax,
                               longint drag, longint lim, longint py, longint dt);
    body_t it;
    it.vel[0] = 32'(vx); it.vel[1] = 32'(vy); it.vel[2] = 32'(vz);
    it.acc[0] = 32'(ax); it.acc[1] = 32'(-ax); it.acc[2] = 32'(ax);
    it.drag = 31'(drag); it.lim = 31'(lim);
    it.pos[0] = 32'sh0001_0000; it.pos[1] = 32'(py); it.pos[2] = -32'sh0003_0000;
    it.dt = 16'(dt);
    return it;
  endfunction

  initial begin
    body_t d [$];
    sb = new();
    sent = 0;
    quiet = 0;
    hold_req = 0;
    rst_ni = 1'b0;
    in_valid_i = 1'b0;
    vel_x_i = 0; vel_y_i = 0; vel_z_i = 0;
    acc_x_i = 0; acc_y_i = 0; acc_z_i = 0;
    drag_coef_i = 0; speed_limit_i = 0;
    pos_x_i = 0; pos_y_i = 0; pos_z_i = 0;
    time_step_i = 0;
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    d.push_back(mk(0, 0, 0, 0, 0, 0, 0, 0));
    d.push_back(mk(32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff,
                   31'h7fffffff, 31'h7fffffff, 32'sh7fffffff, 16'hffff));
    d.push_back(mk(-32'sh80000000, -32'sh80000000, -32'sh80000000, -32'sh80000000,
                   0, 31'h7fffffff, -32'sh80000000, 16'hffff));
    d.push_back(mk(32'sh8000, 0, 0, 0, 0, 31'h7fffffff, 32'sh10000, 0));   // speed exactly half
    d.push_back(mk(32'sh8001, 0, 0, 0, 0, 31'h7fffffff, 32'sh10000, 0));   // just above half
    d.push_back(mk(32'sh50000, 0, 0, 0, 0, 0, 32'sh10000, 16'h1000));     // zero limit stops
    d.push_back(mk(32'sh50000, 32'sh20000, 0, 0, 0, 32'sh30000, 32'sh10000, 16'h4000));
    d.push_back(mk(32'sh30000, 32'sh40000, 0, 0, 0, 32'sh50000, 32'sh10000, 16'h4000)); // at limit
    d.push_back(mk(32'sh30000, 32'sh40000, 0, 0, 0, 32'sh4ffff, 32'sh10000, 16'h4000));
    d.push_back(mk(0, -32'sh40000, 0, 0, 0, 32'sh100000, 32'sh100, 16'hffff)); // below ground
    d.push_back(mk(0, -32'sh10000, 0, 0, 0, 32'sh100000, 32'sh4000, 16'h4000)); // lands at zero
    d.push_back(mk(32'sh20000, 32'sh20000, 32'sh20000, 32'sh10000,
                   32'sh40000, 32'sh1000000, 32'sh10000, 16'h8000)); // negative factor
    d.push_back(mk(32'sh7fff0000, 32'sh10000, 0, 32'sh7fffffff, 0, 31'h7fffffff,
                   32'sh7fff0000, 16'hffff)); // saturation
    d.push_back(mk(-32'sh70000000, 32'sh70000000, -32'sh70000000, 0, 0, 31'h7fffffff,
                   32'sh10000, 16'hffff)); // square sum beyond 63 bits
    d.push_back(mk(32'sh10000, 32'sh10000, 32'sh10000, 32'sh100000, 31'h10000, 32'sh2000,
                   32'sh10000, 16'h0001));
    foreach (d[k]) drive(d[k]);

    for (int n = 0; n < 1950; n++) begin
      quiet = (n >= 400 && n < 700);
      if (n == 800) hold_req = 1;
      if (n == 1200) begin
        in_valid_i = 1'b0;
        while (sb.pending() != 0) @(negedge clk_i);
      end
      drive(rand_body());
    end
    in_valid_i = 1'b0;
    quiet = 0;

    while (sb.pending() != 0) @(negedge clk_i);
    repeat (DRAIN_CYCLES) @(negedge clk_i);
    $display("%0d bodies sent, %0d results checked, %0d errors", sent, sb.checked, sb.errors);
    $display("stopped %0d, speed clamped %0d, ground clamped %0d",
             sb.stopped, sb.clamped, sb.grounded);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("PASS euler_motion_step_with_drag_clamp");
    end else begin
      $display("FAIL euler_motion_step_with_drag_clamp");
    end
    $finish;
  end
endmodule
